>>> hdl/jvts_pkg.sv
// shared types, codes and byte constants for the json value token skipper
`default_nettype none
package jvts_pkg;

   localparam int DEPTH_BITS_DEF  = 8;
   localparam int OFFSET_BITS_DEF = 16;
   localparam int END_OFFSET_W    = 16;
   localparam int STATUS_W        = 3;

   typedef logic [STATUS_W-1:0] status_type;

   localparam status_type ST_BUSY = 3'd0;
   localparam status_type ST_DONE = 3'd1;
   localparam status_type ST_BAD  = 3'd2;
   localparam status_type ST_OVER = 3'd3;
   localparam status_type ST_IDLE = 3'd4;

   typedef enum logic [4:0] {
      MODE_IDLE      = 5'b00001,
      MODE_SPACE     = 5'b00010,
      MODE_STRING    = 5'b00100,
      MODE_CONTAINER = 5'b01000,
      MODE_PRIMITIVE = 5'b10000
   } mode_type;

   localparam logic [7:0] CH_NUL      = 8'h00;
   localparam logic [7:0] CH_SPACE    = 8'h20;
   localparam logic [7:0] CH_TAB      = 8'h09;
   localparam logic [7:0] CH_CR       = 8'h0D;
   localparam logic [7:0] CH_QUOTE    = 8'h22;
   localparam logic [7:0] CH_COMMA    = 8'h2C;
   localparam logic [7:0] CH_LBRACKET = 8'h5B;
   localparam logic [7:0] CH_BSLASH   = 8'h5C;
   localparam logic [7:0] CH_RBRACKET = 8'h5D;
   localparam logic [7:0] CH_LBRACE   = 8'h7B;
   localparam logic [7:0] CH_RBRACE   = 8'h7D;

   function automatic logic is_blank(input logic [7:0] b);
      return ((b >= CH_TAB) && (b <= CH_CR)) || (b == CH_SPACE);
   endfunction

   function automatic logic ends_primitive(input logic [7:0] b);
      return (b == CH_NUL) || (b == CH_COMMA) || (b == CH_RBRACE) || (b == CH_RBRACKET);
   endfunction

endpackage
`default_nettype wire

>>> hdl/json_value_token_skipper_unit.sv
// top level of the json value token skipper: byte scanner with input and result registers
//
// usage:
//   the request channel carries one byte of json text per item (req_text_byte) and a
//   start mark (req_scan_start) on the first byte of a value scan. every accepted item
//   yields exactly one result item: rsp_scan_status (0 busy, 1 done, 2 malformed,
//   3 overflow, 4 idle) and rsp_end_offset, the offset just past the token when done.
//   an item is taken when valid is high and stall is low on its channel.
//   the item is captured in the input register at acceptance, the scan state update
//   runs in shallow logic and the result lands in the result register when the item
//   advances out of the input register.
//   throughput is one item per cycle while the receiver does not stall.
//   when the receiver stalls, the result register holds and the input register keeps
//   accepting until it is full; then req_stall rises.
//   synchronous reset empties both registers and returns the scanner to idle.
`default_nettype none
module json_value_token_skipper_unit #(
   parameter int DEPTH_BITS  = jvts_pkg::DEPTH_BITS_DEF,
   parameter int OFFSET_BITS = jvts_pkg::OFFSET_BITS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output      logic                             req_stall,
   input  wire logic [7:0]                       req_text_byte,
   input  wire logic                             req_scan_start,
   output      logic                             rsp_valid,
   input  wire logic                             rsp_stall,
   output      jvts_pkg::status_type             rsp_scan_status,
   output      logic [jvts_pkg::END_OFFSET_W-1:0] rsp_end_offset
);
   import jvts_pkg::*;

   localparam logic [DEPTH_BITS-1:0]  DEPTH_MAX  = {DEPTH_BITS{1'b1}};
   localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {OFFSET_BITS{1'b1}};

   logic                    in_valid_ff, in_valid_in;
   logic [7:0]              in_byte_ff;
   logic                    in_start_ff;
   logic                    out_valid_ff, out_valid_in;
   status_type              out_status_ff, out_status_in;
   logic [END_OFFSET_W-1:0] out_offset_ff, out_offset_in;

   mode_type                mode_ff, mode_in;
   logic                    escape_ff, escape_in;
   logic                    instr_ff, instr_in;
   logic [DEPTH_BITS-1:0]   brace_ff, brace_in;
   logic [DEPTH_BITS-1:0]   bracket_ff, bracket_in;
   logic [OFFSET_BITS-1:0]  offset_ff, offset_in;

   logic                    advance;
   logic                    accept;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   always_comb begin
      logic [7:0]           b;
      mode_type             m;
      logic                 esc;
      logic                 ins;
      logic [DEPTH_BITS-1:0] brc;
      logic [DEPTH_BITS-1:0] brk;
      logic [OFFSET_BITS-1:0] off;
      logic [OFFSET_BITS:0] endv;
      status_type           st;
      logic                 goes_on;

      b    = in_byte_ff;
      m    = mode_ff;
      esc  = escape_ff;
      ins  = instr_ff;
      brc  = brace_ff;
      brk  = bracket_ff;
      off  = offset_ff;
      endv = '0;
      st   = ST_BUSY;
      goes_on = 1'b0;

      if (in_start_ff) begin
         m   = MODE_SPACE;
         esc = 1'b0;
         ins = 1'b0;
         brc = '0;
         brk = '0;
         off = '0;
      end

      mode_in    = m;
      escape_in  = esc;
      instr_in   = ins;
      brace_in   = brc;
      bracket_in = brk;
      offset_in  = off;

      unique case (m)
         MODE_IDLE: begin
            st = ST_IDLE;
         end
         MODE_SPACE: begin
            priority if (is_blank(b)) begin
            end else if (ends_primitive(b)) begin
               st = ST_BAD;
            end else if (b == CH_QUOTE) begin
               mode_in   = MODE_STRING;
               escape_in = 1'b0;
            end else if (b == CH_LBRACE) begin
               mode_in  = MODE_CONTAINER;
               brace_in = DEPTH_BITS'(1);
            end else if (b == CH_LBRACKET) begin
               mode_in    = MODE_CONTAINER;
               bracket_in = DEPTH_BITS'(1);
            end else begin
               mode_in = MODE_PRIMITIVE;
            end
         end
         MODE_STRING: begin
            priority if (b == CH_NUL) begin
               st = ST_BAD;
            end else if (esc) begin
               escape_in = 1'b0;
            end else if (b == CH_BSLASH) begin
               escape_in = 1'b1;
            end else if (b == CH_QUOTE) begin
               st   = ST_DONE;
               endv = {1'b0, off} + (OFFSET_BITS+1)'(1);
            end else begin
            end
         end
         MODE_PRIMITIVE: begin
            if (ends_primitive(b)) begin
               st   = ST_DONE;
               endv = {1'b0, off};
            end
         end
         MODE_CONTAINER: begin
            priority if (b == CH_NUL) begin
               st = ST_BAD;
            end else if (ins) begin
               priority if (esc) begin
                  escape_in = 1'b0;
               end else if (b == CH_BSLASH) begin
                  escape_in = 1'b1;
               end else if (b == CH_QUOTE) begin
                  instr_in = 1'b0;
               end else begin
               end
            end else if (b == CH_QUOTE) begin
               instr_in  = 1'b1;
               escape_in = 1'b0;
            end else if (b == CH_LBRACE) begin
               if (brc == DEPTH_MAX) st = ST_OVER;
               else brace_in = brc + DEPTH_BITS'(1);
            end else if (b == CH_LBRACKET) begin
               if (brk == DEPTH_MAX) st = ST_OVER;
               else bracket_in = brk + DEPTH_BITS'(1);
            end else begin
               if (b == CH_RBRACE) begin
                  if (brc == '0) st = ST_BAD;
                  else brace_in = brc - DEPTH_BITS'(1);
               end else if (b == CH_RBRACKET) begin
                  if (brk == '0) st = ST_BAD;
                  else bracket_in = brk - DEPTH_BITS'(1);
               end
               if (st == ST_BUSY && brace_in == '0 && bracket_in == '0) begin
                  st   = ST_DONE;
                  endv = {1'b0, off} + (OFFSET_BITS+1)'(1);
               end
            end
         end
         default: begin
            st = ST_IDLE;
         end
      endcase

      if (m != MODE_IDLE) begin
         goes_on = (st == ST_BUSY) || (st == ST_DONE && endv != {1'b0, off});
         if (goes_on) begin
            if (off == OFFSET_MAX) st = ST_OVER;
            else if (st == ST_BUSY) offset_in = off + OFFSET_BITS'(1);
         end
         if (st != ST_BUSY) mode_in = MODE_IDLE;
      end

      out_status_in = st;
      out_offset_in = (st == ST_DONE) ? END_OFFSET_W'(endv) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         mode_ff      <= MODE_IDLE;
         escape_ff    <= 1'b0;
         instr_ff     <= 1'b0;
         brace_ff     <= '0;
         bracket_ff   <= '0;
         offset_ff    <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            mode_ff    <= mode_in;
            escape_ff  <= escape_in;
            instr_ff   <= instr_in;
            brace_ff   <= brace_in;
            bracket_ff <= bracket_in;
            offset_ff  <= offset_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff  <= req_text_byte;
         in_start_ff <= req_scan_start;
      end
      if (advance) begin
         out_status_ff <= out_status_in;
         out_offset_ff <= out_offset_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_scan_status = out_status_ff;
   assign rsp_end_offset  = out_offset_ff;

endmodule
`default_nettype wire

>>> bench/json_value_token_skipper_unit_test.sv
// testbench for the json value token skipper: byte scans checked against a predictor
`timescale 1ns / 1ps
module json_value_token_skipper_unit_test;
   import jvts_pkg::*;

   localparam int GAP_MAX      = 7;
   localparam int QUIET_LIMIT  = 1000;
   localparam int ITEM_TARGET  = 1450;
   localparam int DRAIN_CYCLES = 10;
   localparam int PRINT_LIMIT  = 100;
   localparam int DEPTH_TOP    = (1 << DEPTH_BITS_DEF) - 1;
   localparam int OFFSET_TOP   = (1 << OFFSET_BITS_DEF) - 1;
   localparam int SIDE_REQ     = 0;
   localparam int SIDE_RSP     = 1;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_LF    = 8'h0A;

   typedef struct packed {
      status_type              status;
      logic [END_OFFSET_W-1:0] end_offset;
   } scan_result_type;

   class token_scoreboard;
      mode_type                  mode;
      bit                        esc_pending;
      bit                        quoted;
      logic [DEPTH_BITS_DEF-1:0]  braces;
      logic [DEPTH_BITS_DEF-1:0]  brackets;
      logic [OFFSET_BITS_DEF-1:0] offset;
      scan_result_type           expected_q[$];
      int                        errors;
      int                        results;
      int                        scanned;
      int                        status_seen[5];

      function new();
         mode = MODE_IDLE;
         esc_pending = 1'b0;
         quoted = 1'b0;
         braces = '0;
         brackets = '0;
         offset = '0;
         errors = 0;
         results = 0;
         scanned = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
      endfunction

      function bit is_whitespace(input logic [7:0] b);
         return (b >= CH_TAB && b <= CH_CR) || b == CH_SPACE;
      endfunction

      function bit ends_bare_value(input logic [7:0] b);
         return b == CH_NUL || b == CH_COMMA || b == CH_RBRACE || b == CH_RBRACKET;
      endfunction

      task report(input string msg);
         errors++;
         if (errors <= PRINT_LIMIT) $display("MISMATCH at %0t: %s", $time, msg);
      endtask

      function void note_item(input logic [7:0] b, input logic start);
         status_type                st;
         logic [OFFSET_BITS_DEF:0]  cur;
         logic [OFFSET_BITS_DEF:0]  stop;
         scan_result_type           r;
         st = ST_BUSY;
         stop = '0;
         scanned++;
         if (start) begin
            mode = MODE_SPACE;
            esc_pending = 1'b0;
            quoted = 1'b0;
            braces = '0;
            brackets = '0;
            offset = '0;
         end
         if (mode == MODE_IDLE) begin
            r.status = ST_IDLE;
            r.end_offset = '0;
            expected_q.push_back(r);
            return;
         end
         cur = {1'b0, offset};
         case (mode)
            MODE_SPACE: begin
               if (!is_whitespace(b)) begin
                  if (ends_bare_value(b)) begin
                     st = ST_BAD;
                  end else if (b == CH_QUOTE) begin
                     mode = MODE_STRING;
                     esc_pending = 1'b0;
                  end else if (b == CH_LBRACE) begin
                     mode = MODE_CONTAINER;
                     braces = DEPTH_BITS_DEF'(1);
                  end else if (b == CH_LBRACKET) begin
                     mode = MODE_CONTAINER;
                     brackets = DEPTH_BITS_DEF'(1);
                  end else begin
                     mode = MODE_PRIMITIVE;
                  end
               end
            end
            MODE_STRING: begin
               if (b == CH_NUL) begin
                  st = ST_BAD;
               end else if (esc_pending) begin
                  esc_pending = 1'b0;
               end else if (b == CH_BSLASH) begin
                  esc_pending = 1'b1;
               end else if (b == CH_QUOTE) begin
                  st = ST_DONE;
                  stop = cur + 1'b1;
               end
            end
            MODE_PRIMITIVE: begin
               if (ends_bare_value(b)) begin
                  st = ST_DONE;
                  stop = cur;
               end
            end
            default: begin
               if (b == CH_NUL) begin
                  st = ST_BAD;
               end else if (quoted) begin
                  if (esc_pending) begin
                     esc_pending = 1'b0;
                  end else if (b == CH_BSLASH) begin
                     esc_pending = 1'b1;
                  end else if (b == CH_QUOTE) begin
                     quoted = 1'b0;
                  end
               end else if (b == CH_QUOTE) begin
                  quoted = 1'b1;
                  esc_pending = 1'b0;
               end else if (b == CH_LBRACE) begin
                  if (braces >= DEPTH_TOP) st = ST_OVER;
                  else braces = braces + 1'b1;
               end else if (b == CH_LBRACKET) begin
                  if (brackets >= DEPTH_TOP) st = ST_OVER;
                  else brackets = brackets + 1'b1;
               end else begin
                  if (b == CH_RBRACE) begin
                     if (braces == 0) st = ST_BAD;
                     else braces = braces - 1'b1;
                  end else if (b == CH_RBRACKET) begin
                     if (brackets == 0) st = ST_BAD;
                     else brackets = brackets - 1'b1;
                  end
                  if (st == ST_BUSY && braces == 0 && brackets == 0) begin
                     st = ST_DONE;
                     stop = cur + 1'b1;
                  end
               end
            end
         endcase
         if (st == ST_BUSY || (st == ST_DONE && stop > cur)) begin
            if (cur >= OFFSET_TOP) st = ST_OVER;
            else if (st == ST_BUSY) offset = offset + 1'b1;
         end
         if (st != ST_BUSY) mode = MODE_IDLE;
         r.status = st;
         r.end_offset = (st == ST_DONE) ? stop[END_OFFSET_W-1:0] : '0;
         expected_q.push_back(r);
      endfunction

      task check_result(input status_type status, input logic [END_OFFSET_W-1:0] end_offset);
         scan_result_type exp;
         if (expected_q.size() == 0) begin
            report($sformatf("result with no item waiting: status %0d offset %0d",
                             status, end_offset));
            return;
         end
         exp = expected_q.pop_front();
         results++;
         if (status <= ST_IDLE) status_seen[status]++;
         if (status != exp.status)
            report($sformatf("status %0d, expected %0d", status, exp.status));
         if (end_offset != exp.end_offset)
            report($sformatf("end offset %0d, expected %0d", end_offset, exp.end_offset));
      endtask
   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [7:0]              req_text_byte = 8'h00;
   logic                    req_scan_start = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   status_type              rsp_scan_status;
   logic [END_OFFSET_W-1:0] rsp_end_offset;

   token_scoreboard sb = new;
   logic [7:0]      text_q[$];
   int              calm[2] = '{0, 0};

   json_value_token_skipper_unit DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_text_byte  (req_text_byte),
      .req_scan_start (req_scan_start),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_scan_status(rsp_scan_status),
      .rsp_end_offset (rsp_end_offset)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic int draw_gap(input int side);
      if (calm[side] > 0) begin
         calm[side]--;
         return 0;
      end
      if ($urandom_range(0, 39) == 0) calm[side] = $urandom_range(10, 60);
      return $urandom_range(0, GAP_MAX);
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_item(req_text_byte, req_scan_start);
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_scan_status, rsp_end_offset);
      end
   end

   initial begin
      int n;
      wait (!reset);
      @(posedge clock);
      forever begin
         n = draw_gap(SIDE_RSP);
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("Test completed with failures");
      $finish;
   end

   task automatic send_item(input logic [7:0] b, input logic start);
      int gap;
      gap = draw_gap(SIDE_REQ);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_text_byte <= b;
      req_scan_start <= start;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_text();
      foreach (text_q[i]) send_item(text_q[i], i == 0);
      text_q.delete();
   endtask

   task automatic send_scan(input string s);
      for (int i = 0; i < s.len(); i++) send_item(s[i], i == 0);
   endtask

   function automatic logic [7:0] pick_blank();
      return $urandom_range(0, 1) ? CH_SPACE : 8'($urandom_range(CH_TAB, CH_CR));
   endfunction

   function automatic logic [7:0] pick_text_char();
      logic [7:0] b;
      do b = 8'($urandom_range(1, 255)); while (b == CH_QUOTE || b == CH_BSLASH);
      return b;
   endfunction

   function automatic logic [7:0] pick_bare_char();
      logic [7:0] b;
      do b = 8'($urandom_range(1, 255));
      while (b == CH_COMMA || b == CH_RBRACE || b == CH_RBRACKET);
      return b;
   endfunction

   function automatic logic [7:0] pick_filler();
      logic [7:0] b;
      do b = 8'($urandom_range(1, 255));
      while (b == CH_QUOTE || b == CH_LBRACE || b == CH_RBRACE ||
             b == CH_LBRACKET || b == CH_RBRACKET);
      return b;
   endfunction

   function automatic logic [7:0] pick_terminator();
      case ($urandom_range(0, 3))
         0: return CH_NUL;
         1: return CH_COMMA;
         2: return CH_RBRACE;
         default: return CH_RBRACKET;
      endcase
   endfunction

   function automatic void add_blanks();
      repeat ($urandom_range(0, 2)) text_q.push_back(pick_blank());
   endfunction

   function automatic void add_string();
      text_q.push_back(CH_QUOTE);
      repeat ($urandom_range(0, 8)) begin
         if ($urandom_range(0, 4) == 0) begin
            text_q.push_back(CH_BSLASH);
            text_q.push_back(8'($urandom_range(1, 255)));
         end else begin
            text_q.push_back(pick_text_char());
         end
      end
      text_q.push_back(CH_QUOTE);
   endfunction

   function automatic void add_primitive();
      logic [7:0] b;
      do b = 8'($urandom_range(1, 255));
      while (sb.is_whitespace(b) || sb.ends_bare_value(b) || b == CH_QUOTE ||
             b == CH_LBRACE || b == CH_LBRACKET);
      text_q.push_back(b);
      repeat ($urandom_range(0, 6)) text_q.push_back(pick_bare_char());
      text_q.push_back(pick_terminator());
   endfunction

   function automatic void add_container();
      logic [7:0] closers[$];
      for (int k = 0; k < $urandom_range(1, 14); k++) begin
         if (closers.size() == 0 || ($urandom_range(0, 4) == 0 && closers.size() < 6)) begin
            if ($urandom_range(0, 1)) begin
               text_q.push_back(CH_LBRACE);
               closers.push_back(CH_RBRACE);
            end else begin
               text_q.push_back(CH_LBRACKET);
               closers.push_back(CH_RBRACKET);
            end
         end else begin
            case ($urandom_range(0, 4))
               0: if (closers.size() > 1) text_q.push_back(closers.pop_back());
               1: add_string();
               2: text_q.push_back($urandom_range(0, 1) ? CH_COLON : CH_COMMA);
               3: text_q.push_back(pick_blank());
               default: repeat ($urandom_range(1, 4)) text_q.push_back(pick_filler());
            endcase
         end
      end
      while (closers.size() > 0) text_q.push_back(closers.pop_back());
   endfunction

   function automatic void add_broken();
      case ($urandom_range(0, 3))
         0: begin
            add_blanks();
            text_q.push_back(pick_terminator());
         end
         1: begin
            text_q.push_back(CH_LBRACKET);
            repeat ($urandom_range(0, 3)) text_q.push_back(pick_filler());
            text_q.push_back(CH_RBRACE);
         end
         2: begin
            text_q.push_back(CH_LBRACE);
            repeat ($urandom_range(0, 3)) text_q.push_back(pick_filler());
            text_q.push_back(CH_RBRACKET);
         end
         default: begin
            if ($urandom_range(0, 1)) add_container();
            else add_string();
            while (text_q.size() > 1 && $urandom_range(0, 1)) void'(text_q.pop_back());
            text_q.push_back(CH_NUL);
         end
      endcase
   endfunction

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: idle bytes, each token kind, error cases, restart
      send_item(8'hFF, 1'b0);
      send_item(CH_NUL, 1'b0);
      send_scan(" \t7x,");
      send_scan("\"a\\\"\"");
      send_scan("{\"}\"[]}");
      send_scan("]");
      send_item(CH_NUL, 1'b1);
      send_scan("\"\\");
      send_item(CH_NUL, 1'b0);
      send_scan("[}");
      send_scan("[1");
      send_scan("5");
      send_item(CH_NUL, 1'b0);
      send_item("z", 1'b0);
      send_scan("{\n");
      send_item(CH_NUL, 1'b0);

      // deepest nesting, then one level too many
      repeat (DEPTH_TOP) text_q.push_back(CH_LBRACE);
      repeat (DEPTH_TOP) text_q.push_back(CH_RBRACE);
      send_text();
      repeat (DEPTH_TOP + 1) text_q.push_back(CH_LBRACKET);
      send_text();

      while (sb.scanned < ITEM_TARGET) begin
         case ($urandom_range(0, 9))
            0, 1: begin
               add_blanks();
               add_string();
            end
            2, 3: begin
               add_blanks();
               add_primitive();
            end
            4, 5, 6: begin
               add_blanks();
               add_container();
            end
            7: add_broken();
            default: repeat ($urandom_range(1, 10)) text_q.push_back(8'($urandom_range(0, 255)));
         endcase
         if ($urandom_range(0, 7) == 0)
            while (text_q.size() > 1 && $urandom_range(0, 2)) void'(text_q.pop_back());
         if ($urandom_range(0, 9) == 0) begin
            foreach (text_q[i]) send_item(text_q[i], i == 0 && $urandom_range(0, 3) != 0);
            text_q.delete();
         end else begin
            send_text();
         end
         repeat ($urandom_range(0, 2)) send_item(8'($urandom_range(0, 255)), 1'b0);
      end

      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.expected_q.size() != 0) sb.report("results still missing at the end");

      $display("%0d bytes sent, %0d results checked", sb.scanned, sb.results);
      $display("outcomes: %0d done, %0d malformed, %0d overflow, %0d idle",
               sb.status_seen[ST_DONE], sb.status_seen[ST_BAD],
               sb.status_seen[ST_OVER], sb.status_seen[ST_IDLE]);
      if (sb.errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
